@@ rtl/core/rgbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbm_pkg
// Shared types and constants for the RGB LED matrix scan driver.
// ----------------------------------------------------------------------------
package rgbm_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_CLR     = 2'd2,
    MODE_CLR_ALL = 2'd3
  } mode_t;

  // Scan sequencer phases
  typedef enum logic [2:0] {
    PH_BLANK    = 3'd0,
    PH_CLK_HIGH = 3'd1,
    PH_CLK_LOW  = 3'd2,
    PH_LATCH    = 3'd3,
    PH_ENABLE   = 3'd4
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_IDLE   = 3'd1,
    ST_EXEC   = 3'd2,
    ST_CLEAR  = 3'd3,
    ST_RESULT = 3'd4
  } ctrl_state_t;

  localparam int COLOR_W = 3;
  localparam int CELL_W  = 2 * COLOR_W;
  localparam int ADDR_W  = 5;

  // Input word
  typedef struct packed {
    mode_t                mode;
    logic [6:0]           pixel_row;
    logic [6:0]           pixel_column;
    logic [COLOR_W-1:0]   color_bits;
  } in_word_t;

  // Result word: panel pin levels
  typedef struct packed {
    logic [COLOR_W-1:0] top_rgb;
    logic [COLOR_W-1:0] bottom_rgb;
    logic [ADDR_W-1:0]  row_address;
    logic               shift_clock;
    logic               latch_pin;
    logic               display_enable;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic clr_step;
    logic result_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic item_clear_all;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/rgbm_ram.sv @@
// ----------------------------------------------------------------------------
// rgbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/core/rgbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rgbm_ctrl
// Controller: sequences clear sweeps, item execution and result hand-off.
// ----------------------------------------------------------------------------
module rgbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rgbm_pkg::stat_t stat_i,
  output rgbm_pkg::cmd_t  cmd_o
);
  import rgbm_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (stat_i.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = stat_i.item_clear_all ? ST_CLEAR : ST_RESULT;
      end
      ST_CLEAR: begin
        if (stat_i.clr_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall           = 1'b1;
    cmd_o              = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd_o.accept = in_valid;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_INIT, ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.result_load = stat_i.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  // execution only directly follows an accept
  a_exec_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> $past(state_r) == ST_IDLE)
    else $error("exec without preceding accept");

  // a delivered result frees the block for the next word
  a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.result_load |=> state_r == ST_IDLE)
    else $error("result load did not return to idle");

  // a display clear ends with its result
  a_clear_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && stat_i.clr_last) |=> state_r == ST_RESULT)
    else $error("display clear did not report");
`endif

endmodule

@@ rtl/core/rgbm_dpath.sv @@
// ----------------------------------------------------------------------------
// rgbm_dpath
// Datapath: frame buffer, pixel read-modify-write, scan counters, pin and
// output registers.
// ----------------------------------------------------------------------------
module rgbm_dpath #(
  parameter int HALF_ROWS = 32,
  parameter int COLUMNS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rgbm_pkg::out_word_t out_word,
  input  rgbm_pkg::cmd_t      cmd_i,
  output rgbm_pkg::stat_t     stat_o
);
  import rgbm_pkg::*;

  localparam int DEPTH = HALF_ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(HALF_ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  // scan state
  phase_t          phase_r, phase_nxt;
  logic [RW-1:0]   scan_row_r, scan_row_nxt;
  logic [CW-1:0]   scan_col_r, scan_col_nxt;
  out_word_t       pin_r, pin_nxt;

  // clear sweep
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            clr_last;

  // latched item
  mode_t           mode_r;
  logic [AW-1:0]   wr_addr_r;
  logic [CELL_W-1:0] mask_r;
  logic            acc_ok_r;

  // output register
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r;

  // pixel address decode of the incoming word
  logic            upper_half;
  logic            acc_ok;
  logic [6:0]      cell_row;
  logic [AW-1:0]   pix_addr;
  logic [AW-1:0]   scan_addr;
  logic [CELL_W-1:0] mask;

  // memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] cell_mod;

  // decode pixel access
  always_comb begin
    upper_half = 8'(in_word.pixel_row) >= 8'(HALF_ROWS);
    acc_ok     = (8'(in_word.pixel_row) < 8'(2 * HALF_ROWS)) &&
                 (9'(in_word.pixel_column) < 9'(COLUMNS));
    cell_row   = upper_half ? in_word.pixel_row - 7'(HALF_ROWS) : in_word.pixel_row;
    pix_addr   = AW'(RW'(cell_row)) * COLS_A + AW'(in_word.pixel_column);
    scan_addr  = AW'(scan_row_r) * COLS_A + AW'(scan_col_r);
    mask       = upper_half ? {in_word.color_bits, {COLOR_W{1'b0}}}
                            : {{COLOR_W{1'b0}}, in_word.color_bits};
    ram_raddr  = (in_word.mode == MODE_SCAN) ? scan_addr : pix_addr;
  end

  // item capture at accept
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      mode_r    <= in_word.mode;
      wr_addr_r <= pix_addr;
      mask_r    <= mask;
      acc_ok_r  <= acc_ok;
    end
  end

  // read-modify-write of one cell
  always_comb begin
    case (mode_r)
      MODE_SET: cell_mod = ram_rdata | mask_r;
      MODE_CLR: cell_mod = ram_rdata & ~mask_r;
      default:  cell_mod = ram_rdata;
    endcase
  end

  assign clr_last  = clr_addr_r == AW'(DEPTH - 1);
  assign ram_we    = cmd_i.clr_step ||
                     (cmd_i.exec && acc_ok_r && (mode_r == MODE_SET || mode_r == MODE_CLR));
  assign ram_waddr = cmd_i.clr_step ? clr_addr_r : wr_addr_r;
  assign ram_wdata = cmd_i.clr_step ? '0 : cell_mod;

  rgbm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd_i.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clear sweep counter
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (cmd_i.clr_step) begin
      clr_addr_nxt = clr_last ? '0 : clr_addr_r + AW'(1);
    end
  end

  // scan sequencer step
  always_comb begin
    phase_nxt    = phase_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    pin_nxt      = pin_r;
    if (cmd_i.exec && mode_r == MODE_SCAN) begin
      case (phase_r)
        PH_BLANK: begin
          pin_nxt.display_enable = 1'b0;
          pin_nxt.latch_pin      = 1'b0;
          scan_col_nxt           = '0;
          phase_nxt              = PH_CLK_HIGH;
        end
        PH_CLK_HIGH: begin
          pin_nxt.top_rgb     = ram_rdata[COLOR_W-1:0];
          pin_nxt.bottom_rgb  = ram_rdata[CELL_W-1:COLOR_W];
          pin_nxt.shift_clock = 1'b1;
          phase_nxt           = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          pin_nxt.shift_clock = 1'b0;
          if (scan_col_r == CW'(COLUMNS - 1)) begin
            scan_col_nxt = '0;
            phase_nxt    = PH_LATCH;
          end else begin
            scan_col_nxt = scan_col_r + CW'(1);
            phase_nxt    = PH_CLK_HIGH;
          end
        end
        PH_LATCH: begin
          pin_nxt.latch_pin = 1'b1;
          phase_nxt         = PH_ENABLE;
        end
        default: begin
          pin_nxt.display_enable = 1'b1;
          pin_nxt.row_address    = ADDR_W'(scan_row_r);
          scan_row_nxt = (scan_row_r == RW'(HALF_ROWS - 1)) ? '0 : scan_row_r + RW'(1);
          phase_nxt    = PH_BLANK;
        end
      endcase
    end
  end

  // output register: hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd_i.result_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.result_load) begin
      out_word_r <= pin_r;
    end
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BLANK;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      pin_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      pin_r       <= pin_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign stat_o.clr_last       = clr_last;
  assign stat_o.item_clear_all = mode_r == MODE_CLR_ALL;
  assign stat_o.out_free       = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  // column counter never leaves the panel width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_col_r <= CW'(COLUMNS - 1))
    else $error("scan column out of range");
`endif

endmodule

@@ rtl/core/rgb_led_matrix_scan_driver.sv @@
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver
// Frame buffer and scan-out engine for a two-half HUB75 style RGB panel.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+-------------------------------
//   in      | in  | in_valid/in_stall  | mode, pixel row/column, color
//   out     | out | out_valid/out_stall| pin levels after the word
//
// Each word passes through accept, buffer read and update, and result load,
// with a registered frame buffer read.
// Clear-display walks the buffer one cell per cycle.
// After reset the same sweep runs with in_stall high.
// A stalled result holds the block in its result step until taken.
// ----------------------------------------------------------------------------
module rgb_led_matrix_scan_driver #(
  parameter int HALF_ROWS = 32,
  parameter int COLUMNS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rgbm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rgbm_pkg::out_word_t out_word
);
  import rgbm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rgbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  rgbm_dpath #(
    .HALF_ROWS (HALF_ROWS),
    .COLUMNS   (COLUMNS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule
